// File: src/rtia_pkg.sv
// Shared constants, types and width helpers for the reflection to impedance converter.
package rtia_pkg;

  localparam int GAMMA_WIDTH_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF = 8;
  localparam int MAX_FRAC = 30;
  localparam int Z0_WIDTH = 10;
  localparam logic [Z0_WIDTH-1:0] Z0_RESET = 10'd50;
  localparam int ADMIT_SCALE = 1000;
  localparam int QUO_BITS = 33;
  localparam int RESULT_WIDTH = 32;
  localparam int FRONT_STAGES = 6;

  typedef struct packed {
    logic zden;
    logic yden;
    logic z0zero;
    logic yneg;
    logic ypos;
  } rtia_flags_t;

  function automatic int frac_bits(input int gw);
    return (gw - 1 > MAX_FRAC) ? MAX_FRAC : gw - 1;
  endfunction

  function automatic int num_width(input int gw);
    return 2 * frac_bits(gw) + 2;
  endfunction

  function automatic int den_width(input int gw);
    return 2 * frac_bits(gw) + 3;
  endfunction

  function automatic int prod_width(input int gw, input int ofb);
    return num_width(gw) + Z0_WIDTH + ofb;
  endfunction

  function automatic int adm_den_width(input int gw);
    return den_width(gw) + Z0_WIDTH;
  endfunction

endpackage

// File: src/rtia_point_if.sv
// Input channel carrying one reflection coefficient item.
interface rtia_point_if #(
  parameter int GAMMA_WIDTH = rtia_pkg::GAMMA_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [GAMMA_WIDTH-1:0] gamma_real;
  logic signed [GAMMA_WIDTH-1:0] gamma_imag;

  modport source (output valid, gamma_real, gamma_imag, input ready);
  modport sink (input valid, gamma_real, gamma_imag, output ready);
endinterface

// File: src/rtia_result_if.sv
// Output channel carrying one impedance and admittance item.
interface rtia_result_if;
  logic valid;
  logic ready;
  logic [rtia_pkg::RESULT_WIDTH-1:0] resistance;
  logic signed [rtia_pkg::RESULT_WIDTH-1:0] reactance;
  logic [rtia_pkg::RESULT_WIDTH-1:0] conductance;
  logic signed [rtia_pkg::RESULT_WIDTH-1:0] susceptance;
  logic impedance_saturated;
  logic admittance_saturated;

  modport source (output valid, resistance, reactance, conductance, susceptance,
                  impedance_saturated, admittance_saturated, input ready);
  modport sink (input valid, resistance, reactance, conductance, susceptance,
                impedance_saturated, admittance_saturated, output ready);
endinterface

// File: src/rtia_cfg_if.sv
// Configuration write channel for the reference impedance register.
interface rtia_cfg_if;
  logic valid;
  logic ready;
  logic [rtia_pkg::Z0_WIDTH-1:0] reference_impedance;

  modport source (output valid, reference_impedance, input ready);
  modport sink (input valid, reference_impedance, output ready);
endinterface

// File: src/rtia_div_cell.sv
// One restoring division step producing a single quotient bit.
module rtia_div_cell #(
  parameter int DIV_W = 8,
  parameter int QB = rtia_pkg::QUO_BITS
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [QB-1:0]    low_i,
  input  logic [QB-1:0]    quo_i,
  input  logic [DIV_W-1:0] d_i,
  input  logic             ovf_i,
  output logic [DIV_W-1:0] rem_o,
  output logic [QB-1:0]    low_o,
  output logic [QB-1:0]    quo_o,
  output logic [DIV_W-1:0] d_o,
  output logic             ovf_o
);

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem_i, low_i[QB-1]};
  assign ge = trial >= {1'b0, d_i};
  assign diff = trial - {1'b0, d_i};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_o <= low_i << 1;
      quo_o <= {quo_i[QB-2:0], ge};
      d_o <= d_i;
      ovf_o <= ovf_i;
    end
  end

endmodule

// File: src/rtia_divider.sv
// Pipelined divider built as a row of restoring step cells with an overflow check.
module rtia_divider #(
  parameter int PROD_W = 26,
  parameter int DIV_W = 23,
  parameter int QB = rtia_pkg::QUO_BITS
) (
  input  logic              clk,
  input  logic [QB:0]       en,
  input  logic [PROD_W-1:0] p,
  input  logic [DIV_W-1:0]  d,
  output logic [QB-1:0]     q,
  output logic              ovf
);

  localparam int XW = PROD_W + QB;
  localparam int CW = (PROD_W > DIV_W) ? PROD_W : DIV_W;

  logic [XW-1:0]     px;
  logic [CW-1:0]     hx;
  logic [CW-1:0]     dx;
  logic [DIV_W-1:0]  rem [QB+1];
  logic [QB-1:0]     low [QB+1];
  logic [QB-1:0]     quo [QB+1];
  logic [DIV_W-1:0]  dr [QB+1];
  logic              ov [QB+1];

  assign px = XW'(p);
  assign hx = CW'(px[XW-1:QB]);
  assign dx = CW'(d);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= hx[DIV_W-1:0];
      low[0] <= px[QB-1:0];
      quo[0] <= '0;
      dr[0] <= d;
      ov[0] <= hx >= dx;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_cell
    rtia_div_cell #(.DIV_W(DIV_W), .QB(QB)) u_cell (
      .clk   (clk),
      .en    (en[k+1]),
      .rem_i (rem[k]),
      .low_i (low[k]),
      .quo_i (quo[k]),
      .d_i   (dr[k]),
      .ovf_i (ov[k]),
      .rem_o (rem[k+1]),
      .low_o (low[k+1]),
      .quo_o (quo[k+1]),
      .d_o   (dr[k+1]),
      .ovf_o (ov[k+1])
    );
  end

  assign q = quo[QB];
  assign ovf = ov[QB];

endmodule

// File: src/rtia_front.sv
// Arithmetic front end: magnitudes, squares, sums and split products for the dividers.
module rtia_front #(
  parameter int GAMMA_WIDTH = rtia_pkg::GAMMA_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = rtia_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic [rtia_pkg::FRONT_STAGES-1:0]      en,
  input  logic [rtia_pkg::Z0_WIDTH-1:0]          z0,
  input  logic signed [GAMMA_WIDTH-1:0]          gamma_real,
  input  logic signed [GAMMA_WIDTH-1:0]          gamma_imag,
  output logic [rtia_pkg::prod_width(GAMMA_WIDTH, OUT_FRAC_BITS)-1:0] pz_n,
  output logic [rtia_pkg::prod_width(GAMMA_WIDTH, OUT_FRAC_BITS)-1:0] pz_i,
  output logic [rtia_pkg::prod_width(GAMMA_WIDTH, OUT_FRAC_BITS)-1:0] py_n,
  output logic [rtia_pkg::prod_width(GAMMA_WIDTH, OUT_FRAC_BITS)-1:0] py_i,
  output logic [rtia_pkg::den_width(GAMMA_WIDTH)-1:0]                 dz,
  output logic [rtia_pkg::adm_den_width(GAMMA_WIDTH)-1:0]             dy,
  output rtia_pkg::rtia_flags_t                  flags
);

  localparam int F = rtia_pkg::frac_bits(GAMMA_WIDTH);
  localparam int SH = GAMMA_WIDTH - 1 - F;
  localparam int MW = F + 1;
  localparam int EW = F + 2;
  localparam int NW = rtia_pkg::num_width(GAMMA_WIDTH);
  localparam int DW = rtia_pkg::den_width(GAMMA_WIDTH);
  localparam int ZW = rtia_pkg::Z0_WIDTH + OUT_FRAC_BITS;
  localparam int PW = rtia_pkg::prod_width(GAMMA_WIDTH, OUT_FRAC_BITS);
  localparam int YW = rtia_pkg::adm_den_width(GAMMA_WIDTH);
  localparam int HN = (NW + 1) / 2;
  localparam int HD = (DW + 1) / 2;
  localparam int LNW = HN + ZW;
  localparam int UNW = NW - HN + ZW;
  localparam int LDW = HD + rtia_pkg::Z0_WIDTH;
  localparam int UDW = DW - HD + rtia_pkg::Z0_WIDTH;
  localparam logic signed [F+2:0] SCALE = (F + 3)'(1) << F;

  logic signed [GAMMA_WIDTH-1:0] xs;
  logic signed [GAMMA_WIDTH-1:0] ys;
  logic signed [F:0]   xa;
  logic signed [F:0]   ya;
  logic signed [F+2:0] xe;
  logic signed [F+2:0] ye;
  logic signed [F+2:0] axe;
  logic signed [F+2:0] aye;
  logic signed [F+2:0] dme;
  logic signed [F+2:0] dpe;
  logic [MW-1:0] bx;
  logic [MW-1:0] by;
  logic [EW-1:0] bdm;
  logic [EW-1:0] bdp;
  rtia_pkg::rtia_flags_t bfl;
  logic [2*MW-1:0] cx2;
  logic [2*MW-1:0] cy2;
  logic [2*EW-1:0] cdm2;
  logic [2*EW-1:0] cdp2;
  logic [MW-1:0]   cy;
  rtia_pkg::rtia_flags_t cfl;
  logic [NW-1:0] sq;
  logic [NW-1:0] s2;
  logic [NW-1:0] dnum;
  logic [NW-1:0] dinum;
  logic [DW-1:0] ddz;
  logic [DW-1:0] ddy;
  rtia_pkg::rtia_flags_t dfl;
  logic [ZW-1:0] mz;
  logic [ZW-1:0] my;
  logic [LNW-1:0] enz_lo;
  logic [UNW-1:0] enz_hi;
  logic [LNW-1:0] eiz_lo;
  logic [UNW-1:0] eiz_hi;
  logic [LNW-1:0] eny_lo;
  logic [UNW-1:0] eny_hi;
  logic [LNW-1:0] eiy_lo;
  logic [UNW-1:0] eiy_hi;
  logic [LDW-1:0] edy_lo;
  logic [UDW-1:0] edy_hi;
  logic [DW-1:0]  edz;
  rtia_pkg::rtia_flags_t efl;

  assign xs = gamma_real >>> SH;
  assign ys = gamma_imag >>> SH;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xa <= xs[F:0];
      ya <= ys[F:0];
    end
  end

  assign xe = (F + 3)'(xa);
  assign ye = (F + 3)'(ya);
  assign axe = xe[F+2] ? -xe : xe;
  assign aye = ye[F+2] ? -ye : ye;
  assign dme = SCALE - xe;
  assign dpe = SCALE + xe;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      bx <= axe[MW-1:0];
      by <= aye[MW-1:0];
      bdm <= dme[EW-1:0];
      bdp <= dpe[EW-1:0];
      bfl <= '{zden: 1'b0, yden: 1'b0, z0zero: 1'b0,
               yneg: ya[F], ypos: !ya[F] && (ya != '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cx2 <= (2 * MW)'(bx) * (2 * MW)'(bx);
      cy2 <= (2 * MW)'(by) * (2 * MW)'(by);
      cdm2 <= (2 * EW)'(bdm) * (2 * EW)'(bdm);
      cdp2 <= (2 * EW)'(bdp) * (2 * EW)'(bdp);
      cy <= by;
      cfl <= bfl;
    end
  end

  assign sq = NW'(cx2) + NW'(cy2);
  assign s2 = NW'(1) << (2 * F);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dnum <= (sq > s2) ? sq - s2 : s2 - sq;
      dinum <= NW'(cy) << (F + 1);
      ddz <= DW'(cdm2) + DW'(cy2);
      ddy <= DW'(cdp2) + DW'(cy2);
      dfl <= cfl;
    end
  end

  assign mz = ZW'(z0) << OUT_FRAC_BITS;
  assign my = ZW'(rtia_pkg::ADMIT_SCALE) << OUT_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      enz_lo <= LNW'(dnum[HN-1:0]) * LNW'(mz);
      enz_hi <= UNW'(dnum[NW-1:HN]) * UNW'(mz);
      eiz_lo <= LNW'(dinum[HN-1:0]) * LNW'(mz);
      eiz_hi <= UNW'(dinum[NW-1:HN]) * UNW'(mz);
      eny_lo <= LNW'(dnum[HN-1:0]) * LNW'(my);
      eny_hi <= UNW'(dnum[NW-1:HN]) * UNW'(my);
      eiy_lo <= LNW'(dinum[HN-1:0]) * LNW'(my);
      eiy_hi <= UNW'(dinum[NW-1:HN]) * UNW'(my);
      edy_lo <= LDW'(ddy[HD-1:0]) * LDW'(z0);
      edy_hi <= UDW'(ddy[DW-1:HD]) * UDW'(z0);
      edz <= ddz;
      efl <= '{zden: ddz == '0, yden: ddy == '0, z0zero: z0 == '0,
               yneg: dfl.yneg, ypos: dfl.ypos};
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pz_n <= PW'(enz_lo) + (PW'(enz_hi) << HN);
      pz_i <= PW'(eiz_lo) + (PW'(eiz_hi) << HN);
      py_n <= PW'(eny_lo) + (PW'(eny_hi) << HN);
      py_i <= PW'(eiy_lo) + (PW'(eiy_hi) << HN);
      dy <= YW'(edy_lo) + (YW'(edy_hi) << HD);
      dz <= edz;
      flags <= efl;
    end
  end

endmodule

// File: src/reflection_to_impedance_admittance.sv
// Top level: reflection coefficient to impedance and admittance converter.
//
// The point channel takes one reflection coefficient item (gamma_real, gamma_imag,
// signed with GAMMA_WIDTH-1 fraction bits). The result channel returns one item per
// point: resistance and reactance in 1/2^OUT_FRAC_BITS ohm, conductance and
// susceptance in 1/2^OUT_FRAC_BITS millisiemens, plus a saturation flag per side.
// The cfg channel writes the reference impedance in whole ohms; it is always ready
// and must only be written while no item is in flight.
// The item crosses six front end stages, one overflow check stage, 33 division cells
// and the output register, the first of which loads at the accepting edge.
// Throughput is one item per cycle while the result channel is not stalled, as the
// division cells each finish one quotient bit for a different item.
// Each stage advances when it is empty or its successor advances, so a stalled
// receiver first lets bubbles close up and only then deasserts ready on the point
// channel. Reset empties the pipeline and sets the reference impedance to 50 ohms.
module reflection_to_impedance_admittance #(
  parameter int GAMMA_WIDTH = rtia_pkg::GAMMA_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = rtia_pkg::OUT_FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  rtia_point_if.sink   point,
  rtia_result_if.source result,
  rtia_cfg_if.sink     cfg
);

  localparam int QB = rtia_pkg::QUO_BITS;
  localparam int FRONT = rtia_pkg::FRONT_STAGES;
  localparam int DIVS = QB + 1;
  localparam int L = FRONT + DIVS + 1;
  localparam int PW = rtia_pkg::prod_width(GAMMA_WIDTH, OUT_FRAC_BITS);
  localparam int DW = rtia_pkg::den_width(GAMMA_WIDTH);
  localparam int YW = rtia_pkg::adm_den_width(GAMMA_WIDTH);
  localparam int RW = rtia_pkg::RESULT_WIDTH;
  localparam logic [QB-1:0] POS_LIM = QB'(33'h0_7FFF_FFFF);
  localparam logic [QB-1:0] NEG_LIM = QB'(33'h0_8000_0000);
  localparam logic [RW-1:0] U_MAX = '1;

  logic [rtia_pkg::Z0_WIDTH-1:0] z0;
  logic [L-1:0] v;
  logic [L-1:0] en;
  logic [PW-1:0] pz_n;
  logic [PW-1:0] pz_i;
  logic [PW-1:0] py_n;
  logic [PW-1:0] py_i;
  logic [DW-1:0] dz;
  logic [YW-1:0] dy;
  rtia_pkg::rtia_flags_t ffl;
  rtia_pkg::rtia_flags_t fl [DIVS];
  rtia_pkg::rtia_flags_t of;
  logic [QB-1:0] qa;
  logic [QB-1:0] qb;
  logic [QB-1:0] qc;
  logic [QB-1:0] qd;
  logic oa;
  logic ob;
  logic oc;
  logic od;
  logic [RW-1:0] res_next;
  logic [RW-1:0] reac_next;
  logic [RW-1:0] cond_next;
  logic [RW-1:0] susc_next;
  logic zsat_next;
  logic ysat_next;
  logic [QB-1:0] zlim;
  logic [QB-1:0] ylim;
  logic [QB-1:0] zmag;
  logic [QB-1:0] ymag;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      z0 <= rtia_pkg::Z0_RESET;
    end else if (cfg.valid) begin
      z0 <= cfg.reference_impedance;
    end
  end

  assign en[L-1] = !v[L-1] || result.ready;
  for (genvar i = 0; i < L - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign point.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < L; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? point.valid : v[i-1];
        end
      end
    end
  end

  rtia_front #(.GAMMA_WIDTH(GAMMA_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_front (
    .clk        (clk),
    .en         (en[FRONT-1:0]),
    .z0         (z0),
    .gamma_real (point.gamma_real),
    .gamma_imag (point.gamma_imag),
    .pz_n       (pz_n),
    .pz_i       (pz_i),
    .py_n       (py_n),
    .py_i       (py_i),
    .dz         (dz),
    .dy         (dy),
    .flags      (ffl)
  );

  rtia_divider #(.PROD_W(PW), .DIV_W(DW), .QB(QB)) u_div_r (
    .clk (clk), .en (en[FRONT+DIVS-1:FRONT]), .p (pz_n), .d (dz), .q (qa), .ovf (oa)
  );

  rtia_divider #(.PROD_W(PW), .DIV_W(DW), .QB(QB)) u_div_x (
    .clk (clk), .en (en[FRONT+DIVS-1:FRONT]), .p (pz_i), .d (dz), .q (qb), .ovf (ob)
  );

  rtia_divider #(.PROD_W(PW), .DIV_W(YW), .QB(QB)) u_div_g (
    .clk (clk), .en (en[FRONT+DIVS-1:FRONT]), .p (py_n), .d (dy), .q (qc), .ovf (oc)
  );

  rtia_divider #(.PROD_W(PW), .DIV_W(YW), .QB(QB)) u_div_b (
    .clk (clk), .en (en[FRONT+DIVS-1:FRONT]), .p (py_i), .d (dy), .q (qd), .ovf (od)
  );

  always_ff @(posedge clk) begin
    if (en[FRONT]) begin
      fl[0] <= ffl;
    end
    for (int k = 1; k < DIVS; k++) begin
      if (en[FRONT+k]) begin
        fl[k] <= fl[k-1];
      end
    end
  end

  assign of = fl[DIVS-1];
  assign zlim = of.yneg ? NEG_LIM : POS_LIM;
  assign ylim = of.ypos ? NEG_LIM : POS_LIM;
  assign zmag = (ob || qb > zlim) ? zlim : qb;
  assign ymag = (od || qd > ylim) ? ylim : qd;

  always_comb begin
    if (of.zden) begin
      res_next = U_MAX;
      reac_next = '0;
      zsat_next = 1'b1;
    end else begin
      res_next = (oa || qa[QB-1]) ? U_MAX : qa[RW-1:0];
      reac_next = of.yneg ? -zmag[RW-1:0] : zmag[RW-1:0];
      zsat_next = oa || qa[QB-1] || ob || qb > zlim;
    end
    if (of.yden) begin
      cond_next = U_MAX;
      susc_next = '0;
      ysat_next = 1'b1;
    end else if (of.z0zero) begin
      cond_next = U_MAX;
      susc_next = of.ypos ? NEG_LIM[RW-1:0] : (of.yneg ? POS_LIM[RW-1:0] : '0);
      ysat_next = 1'b1;
    end else begin
      cond_next = (oc || qc[QB-1]) ? U_MAX : qc[RW-1:0];
      susc_next = of.ypos ? -ymag[RW-1:0] : ymag[RW-1:0];
      ysat_next = oc || qc[QB-1] || od || qd > ylim;
    end
  end

  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      result.resistance <= res_next;
      result.reactance <= reac_next;
      result.conductance <= cond_next;
      result.susceptance <= susc_next;
      result.impedance_saturated <= zsat_next;
      result.admittance_saturated <= ysat_next;
    end
  end

  assign result.valid = v[L-1];

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> v[0])
    else $error("accepted item did not enter the first stage");

  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !point.ready |-> v[0] && v[L-1] && !result.ready)
    else $error("input stalled while the pipeline had room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
